/* design/jpeg_header_size_parser_defines.svh */
// ----------------------------------------------------------------------------
// jpeg_header_size_parser_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef JPEG_HEADER_SIZE_PARSER_DEFINES_SVH
`define JPEG_HEADER_SIZE_PARSER_DEFINES_SVH

// same-cycle implication
`define JHSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("jhsp assertion failed");

// next-cycle implication
`define JHSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jhsp assertion failed");

`endif

/* design/jhsp_pkg.sv */
// ----------------------------------------------------------------------------
// jhsp_pkg
// shared types and constants of the jpeg header size parser
// ----------------------------------------------------------------------------
package jhsp_pkg;

  localparam int unsigned DimW = 16;
  localparam int unsigned OutDimW = DimW + 1;

  localparam logic [7:0] BYTE_MARK = 8'hFF;
  localparam logic [7:0] BYTE_SOI  = 8'hD8;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] BYTE_SOS  = 8'hDA;
  localparam logic [7:0] BYTE_EOI  = 8'hD9;

  localparam logic [7:0] SAMP_420  = 8'h22;
  localparam logic [7:0] SAMP_422  = 8'h21;
  localparam logic [7:0] SAMP_444  = 8'h11;
  localparam logic [7:0] SAMP_GRAY = 8'h01;

  localparam logic [7:0] COMP_CMYK = 8'd4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_START   = 3'd1,
    ST_BAD_MARKER  = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_NO_FRAME    = 3'd4
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [OutDimW-1:0]   width;
    logic [OutDimW-1:0]   height;
  } align_t;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [OutDimW-1:0]   width;
    logic [OutDimW-1:0]   height;
    logic [7:0]           comp;
    logic [7:0]           samp;
  } result_t;

endpackage

/* design/jhsp_if.sv */
// ----------------------------------------------------------------------------
// jhsp_if
// valid/ready channels of the jpeg header size parser
// ----------------------------------------------------------------------------
interface jhsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jhsp_cfg_if;
  logic valid;
  logic ready;
  logic align_enable;

  modport source (output valid, output align_enable, input ready);
  modport sink   (input valid, input align_enable, output ready);
endinterface

interface jhsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [jhsp_pkg::OutDimW-1:0]  image_width;
  logic [jhsp_pkg::OutDimW-1:0]  image_height;
  logic [7:0]                    component_count;
  logic [7:0]                    sampling_factors;

  modport source (output valid, output status, output image_width, output image_height,
                  output component_count, output sampling_factors, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input component_count, input sampling_factors, output ready);
endinterface

/* design/jhsp_align.sv */
// ----------------------------------------------------------------------------
// jhsp_align
// sampling check and dimension rounding, when enabled, at the first sampling byte of the frame header
// ----------------------------------------------------------------------------
module jhsp_align (
  input  logic                          align_enable_i,
  input  logic [jhsp_pkg::DimW-1:0]     width_i,
  input  logic [jhsp_pkg::DimW-1:0]     height_i,
  input  logic [7:0]                    comp_i,
  input  logic [7:0]                    samp_i,
  output jhsp_pkg::align_t              align_o
);

  localparam int unsigned W = jhsp_pkg::OutDimW;

  logic         known;
  logic [W-1:0] w_ext;
  logic [W-1:0] h_ext;
  logic [W-1:0] w_r16;
  logic [W-1:0] w_r8;
  logic [W-1:0] h_r16;
  logic [W-1:0] h_r8;

  assign known = samp_i inside {jhsp_pkg::SAMP_420, jhsp_pkg::SAMP_422,
                                jhsp_pkg::SAMP_444, jhsp_pkg::SAMP_GRAY};
  assign w_ext = {1'b0, width_i};
  assign h_ext = {1'b0, height_i};
  assign w_r16 = (w_ext + W'(15)) & ~W'(15);
  assign w_r8  = (w_ext + W'(7)) & ~W'(7);
  assign h_r16 = (h_ext + W'(15)) & ~W'(15);
  assign h_r8  = (h_ext + W'(7)) & ~W'(7);

  always_comb begin
    align_o.status = jhsp_pkg::ST_OK;
    align_o.width  = w_ext;
    align_o.height = h_ext;
    if (align_enable_i) begin
      if (comp_i == jhsp_pkg::COMP_CMYK || !known) begin
        align_o.status = jhsp_pkg::ST_UNSUPPORTED;
        align_o.width  = '0;
        align_o.height = '0;
      end else begin
        align_o.width  = (samp_i == jhsp_pkg::SAMP_420 || samp_i == jhsp_pkg::SAMP_422)
                         ? w_r16 : w_r8;
        align_o.height = (samp_i == jhsp_pkg::SAMP_420) ? h_r16 : h_r8;
      end
    end
  end

endmodule

/* design/jhsp_parse.sv */
// ----------------------------------------------------------------------------
// jhsp_parse
// marker walk state and per-byte decision logic
// ----------------------------------------------------------------------------
module jhsp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               align_enable_i,
  output jhsp_pkg::result_t  res_o
);

  localparam logic [3:0] PH_SOI0   = 4'd0;
  localparam logic [3:0] PH_SOI1   = 4'd1;
  localparam logic [3:0] PH_MK0    = 4'd2;
  localparam logic [3:0] PH_MK1    = 4'd3;
  localparam logic [3:0] PH_LEN0   = 4'd4;
  localparam logic [3:0] PH_LEN1   = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;
  localparam logic [3:0] PH_SOFPRE = 4'd7;
  localparam logic [3:0] PH_SOF    = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;

  localparam int unsigned DW = jhsp_pkg::DimW;

  logic [3:0]    phase_q, phase_d;
  logic [15:0]   skip_q, skip_d;
  logic [2:0]    idx_q, idx_d;
  logic [DW-1:0] height_q, height_d;
  logic [DW-1:0] width_q, width_d;
  logic [7:0]    comp_q, comp_d;
  logic          done_q, done_d;

  logic [15:0]       len;
  logic [15:0]       skip_dec;
  logic              decide;
  jhsp_pkg::align_t  align;

  jhsp_align u_align (
    .align_enable_i (align_enable_i),
    .width_i        (width_q),
    .height_i       (height_q),
    .comp_i         (comp_q),
    .samp_i         (data_byte_i),
    .align_o        (align)
  );

  assign len      = {skip_q[7:0], data_byte_i};
  assign skip_dec = skip_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    idx_d    = idx_q;
    height_d = height_q;
    width_d  = width_q;
    comp_d   = comp_q;
    done_d   = done_q;
    decide   = 1'b0;
    res_o    = '0;

    case (phase_q)
      PH_SOI0: begin
        if (data_byte_i == jhsp_pkg::BYTE_MARK) begin
          phase_d = PH_SOI1;
        end else begin
          decide       = 1'b1;
          res_o.status = jhsp_pkg::ST_BAD_START;
        end
      end
      PH_SOI1: begin
        if (data_byte_i == jhsp_pkg::BYTE_SOI) begin
          phase_d = PH_MK0;
        end else begin
          decide       = 1'b1;
          res_o.status = jhsp_pkg::ST_BAD_START;
        end
      end
      PH_MK0: begin
        if (data_byte_i == jhsp_pkg::BYTE_MARK) begin
          phase_d = PH_MK1;
        end else begin
          decide       = 1'b1;
          res_o.status = jhsp_pkg::ST_BAD_MARKER;
        end
      end
      PH_MK1: begin
        if (data_byte_i == jhsp_pkg::BYTE_SOF0) begin
          skip_d  = 16'd3;
          phase_d = PH_SOFPRE;
        end else if (data_byte_i == jhsp_pkg::BYTE_SOS ||
                     data_byte_i == jhsp_pkg::BYTE_EOI) begin
          decide       = 1'b1;
          res_o.status = jhsp_pkg::ST_NO_FRAME;
        end else begin
          phase_d = PH_LEN0;
        end
      end
      PH_LEN0: begin
        skip_d  = {8'd0, data_byte_i};
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        if (len < 16'd2) begin
          decide       = 1'b1;
          res_o.status = jhsp_pkg::ST_BAD_MARKER;
        end else begin
          skip_d  = len - 16'd2;
          phase_d = (len == 16'd2) ? PH_MK0 : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_MK0;
        end
      end
      PH_SOFPRE: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          idx_d   = '0;
          phase_d = PH_SOF;
        end
      end
      PH_SOF: begin
        idx_d = idx_q + 3'd1;
        case (idx_q)
          3'd0, 3'd1: height_d = {height_q[DW-9:0], data_byte_i};
          3'd2, 3'd3: width_d  = {width_q[DW-9:0], data_byte_i};
          3'd4:       comp_d   = data_byte_i;
          3'd5:       ;
          default: begin
            decide       = 1'b1;
            res_o.status = align.status;
            if (align.status == jhsp_pkg::ST_OK) begin
              res_o.width  = align.width;
              res_o.height = align.height;
              res_o.comp   = comp_q;
              res_o.samp   = data_byte_i;
            end
          end
        endcase
      end
      default: ;
    endcase

    if (decide) begin
      phase_d = PH_DONE;
      done_d  = 1'b1;
    end
    res_o.valid = decide;

    if (last_byte_i) begin
      if (!done_q && !decide) begin
        res_o.valid  = 1'b1;
        res_o.status = (phase_d == PH_SOI1) ? jhsp_pkg::ST_BAD_START : jhsp_pkg::ST_NO_FRAME;
      end
      phase_d  = PH_SOI0;
      skip_d   = '0;
      idx_d    = '0;
      height_d = '0;
      width_d  = '0;
      comp_d   = '0;
      done_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SOI0;
      skip_q   <= '0;
      idx_q    <= '0;
      height_q <= '0;
      width_q  <= '0;
      comp_q   <= '0;
      done_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      idx_q    <= idx_d;
      height_q <= height_d;
      width_q  <= width_d;
      comp_q   <= comp_d;
      done_q   <= done_d;
    end
  end

endmodule

/* design/jpeg_header_size_parser.sv */
// ----------------------------------------------------------------------------
// jpeg_header_size_parser
// frame size extraction from a jpeg byte stream, one result per image
// ----------------------------------------------------------------------------
// Bytes enter through an input register, one per cycle while the input is not
// stalled; each byte is parsed by the marker state machine and any result is
// loaded into an output register, so the request that decides a result goes
// through the input register and then the output register, and the sustained
// rate is one byte per clock while the receiver takes results. A result that
// is held off by the receiver stops the parser; one more request can wait in
// the input register before the input stalls. The user must write align_enable
// through the config channel only while the stream is idle; the block itself
// does not enforce this. There is no clearing pass after reset.
module jpeg_header_size_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  jhsp_in_if.sink       in_i,
  jhsp_cfg_if.sink      cfg_i,
  jhsp_out_if.source    out_o
);

  logic              align_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              step;
  jhsp_pkg::result_t res;
  jhsp_pkg::result_t out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= 1'b0;
    end else if (cfg_i.valid) begin
      align_q <= cfg_i.align_enable;
    end
  end

  assign step       = in_vld_q && (!out_q.valid || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  jhsp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (in_byte_q),
    .last_byte_i    (in_last_q),
    .align_enable_i (align_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (step) begin
      out_q.valid <= res.valid;
      if (res.valid) begin
        out_q.status <= res.status;
        out_q.width  <= res.width;
        out_q.height <= res.height;
        out_q.comp   <= res.comp;
        out_q.samp   <= res.samp;
      end
    end else if (out_o.ready) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_o.valid            = out_q.valid;
  assign out_o.status           = out_q.status;
  assign out_o.image_width      = out_q.width;
  assign out_o.image_height     = out_q.height;
  assign out_o.component_count  = out_q.comp;
  assign out_o.sampling_factors = out_q.samp;

endmodule

/* design/jhsp_checker.sv */
// ----------------------------------------------------------------------------
// jhsp_port_checker
// port-level assertions bound to the jpeg header size parser
// ----------------------------------------------------------------------------
`include "jpeg_header_size_parser_defines.svh"

module jhsp_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [2:0]                    status_i,
  input logic [jhsp_pkg::OutDimW-1:0]  width_i,
  input logic [jhsp_pkg::OutDimW-1:0]  height_i,
  input logic [7:0]                    comp_i,
  input logic [7:0]                    samp_i
);

  logic [3+2*jhsp_pkg::OutDimW+15:0] held;
  logic                              stalled;
  logic                              fail_seen;
  logic                              fields_zero;

  assign held        = {status_i, width_i, height_i, comp_i, samp_i};
  assign stalled     = out_valid_i && !out_ready_i;
  assign fail_seen   = out_valid_i && status_i != 3'(jhsp_pkg::ST_OK);
  assign fields_zero = width_i == '0 && height_i == '0 && comp_i == '0 && samp_i == '0;

  `JHSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i && $stable(held))
  `JHSP_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_i, status_i <= 3'(jhsp_pkg::ST_NO_FRAME))
  `JHSP_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, fail_seen, fields_zero)
  `JHSP_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind jpeg_header_size_parser jhsp_port_checker u_jhsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .width_i     (out_o.image_width),
  .height_i    (out_o.image_height),
  .comp_i      (out_o.component_count),
  .samp_i      (out_o.sampling_factors)
);
